// ===== sv/fgsr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fgsr_pkg
// Shared types and constants for the fence-gated slot reclaim block.
// ---------------------------------------------------------------------------
package fgsr_pkg;

    localparam int SLOT_COUNT_DEF    = 1024;
    localparam int GEN_BITS_DEF      = 16;
    localparam int PENDING_DEPTH_DEF = 32;
    localparam int QUEUE_COUNT_DEF   = 4;
    localparam int DOMAIN_COUNT_DEF  = 16;
    localparam int MAX_RESULTS       = 32;

    localparam int IN_W   = 2 + 10 + 16 + 1 + 4 + 2 + 64 + 64;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 3 + 16 + 1 + 10 + 4;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_STAMP   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PROCESS = 2'd2,
        OP_CHECK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_STAMPED  = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_INVALID  = 3'd2,
        ST_PENDING  = 3'd3,
        ST_FULL     = 3'd4,
        ST_FREED    = 3'd5,
        ST_NONE     = 3'd6,
        ST_CHECKED  = 3'd7
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [9:0]  slot;
        logic [15:0] gen;
        logic        hvalid;
        logic [3:0]  dom;
        logic [1:0]  queue;
        logic [63:0] fence;
        logic [63:0] done;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [15:0] gen;
        logic        cur;
        logic [9:0]  slot;
        logic [3:0]  dom;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_SCAN,
        S_PICK,
        S_FREE,
        S_EMIT,
        S_CLEAR
    } t_state;

endpackage

// ===== sv/fgsr_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fgsr_front
// Input stage: unpacks items into a short command queue.
// ---------------------------------------------------------------------------
module fgsr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [fgsr_pkg::IN_TW-1:0] i_data,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output fgsr_pkg::t_cmd       o_cmd
);
    fgsr_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    fgsr_pkg::t_cmd w_cmd;
    logic       w_push, w_pop;

    assign w_cmd.op     = fgsr_pkg::t_op'(i_data[1:0]);
    assign w_cmd.slot   = i_data[11:2];
    assign w_cmd.gen    = i_data[27:12];
    assign w_cmd.hvalid = i_data[28];
    assign w_cmd.dom    = i_data[32:29];
    assign w_cmd.queue  = i_data[34:33];
    assign w_cmd.fence  = i_data[98:35];
    assign w_cmd.done   = i_data[162:99];

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue overflow");
    a_cnt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count");
`endif
endmodule

// ===== sv/fgsr_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fgsr_back
// Execution stage: slot tables, deferred-free table and result register.
// ---------------------------------------------------------------------------
module fgsr_back #(
    parameter int SLOT_COUNT    = fgsr_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS      = fgsr_pkg::GEN_BITS_DEF,
    parameter int PENDING_DEPTH = fgsr_pkg::PENDING_DEPTH_DEF,
    parameter int QUEUE_COUNT   = fgsr_pkg::QUEUE_COUNT_DEF,
    parameter int DOMAIN_COUNT  = fgsr_pkg::DOMAIN_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  fgsr_pkg::t_cmd i_cmd,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output fgsr_pkg::t_res o_res
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    logic [GEN_BITS-1:0] m_gen [SLOT_COUNT];
    logic                m_pend [SLOT_COUNT];
    logic [SW-1:0]       r_clr;

    logic [PENDING_DEPTH-1:0] r_ev;
    logic [63:0] r_ef [PENDING_DEPTH];
    logic [SW-1:0] r_es [PENDING_DEPTH];
    logic [3:0]  r_ed [PENDING_DEPTH];
    logic [1:0]  r_eq [PENDING_DEPTH];
    logic [15:0] r_ea [PENDING_DEPTH];
    logic [15:0] r_arr;

    fgsr_pkg::t_state r_st, n_st;
    fgsr_pkg::t_cmd   r_cmd;
    logic [GEN_BITS-1:0] r_rgen;
    logic                r_rpend;
    logic [PW-1:0] r_idx;
    logic          r_hav;
    logic [PW-1:0] r_best;
    logic [5:0]    r_n;
    logic          r_ov;
    fgsr_pkg::t_res r_res;
    fgsr_pkg::t_res r_hold;
    logic           r_hheld;

    logic [SW-1:0] w_slot;
    logic          w_sin;
    logic [GEN_BITS-1:0] w_gen;
    logic          w_cur;
    logic          w_qok;
    logic          w_free_any;
    logic [PW-1:0] w_free_idx;
    logic          w_cand, w_better;
    logic [SW-1:0] w_fslot;
    logic          w_scan_end;
    logic          w_acc;
    fgsr_pkg::t_res w_dres, w_fres, w_lres, w_nres;

    function automatic logic [SW-1:0] i_cmd_slot_trunc(input logic [9:0] s);
        logic [31:0] t;
        t = 32'(s);
        return t[SW-1:0];
    endfunction
    assign w_slot = i_cmd_slot_trunc(r_cmd.slot);
    assign w_sin  = 32'(r_cmd.slot) < SLOT_COUNT;
    assign w_gen  = r_rgen;
    assign w_cur  = r_cmd.hvalid && w_sin && (32'(w_gen) == 32'(r_cmd.gen));
    assign w_qok  = 32'(r_cmd.queue) < QUEUE_COUNT;
    assign w_fslot = r_es[r_best];

    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
            if (!r_ev[i]) begin
                w_free_any = 1'b1;
                w_free_idx = PW'(i);
            end
        end
    end

    assign w_cand = r_ev[r_idx] && r_eq[r_idx] == r_cmd.queue
                    && r_ef[r_idx] <= r_cmd.done;
    assign w_better = !r_hav || r_ef[r_idx] < r_ef[r_best]
                      || (r_ef[r_idx] == r_ef[r_best] && r_ea[r_idx] < r_ea[r_best]);
    assign w_scan_end = 32'(r_idx) == PENDING_DEPTH - 1;

    assign o_cmd_ready = (r_st == fgsr_pkg::S_IDLE) && !r_ov;
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    always_comb begin
        w_dres      = '0;
        w_dres.last = 1'b1;
        w_acc       = 1'b0;
        case (r_cmd.op)
            fgsr_pkg::OP_STAMP: begin
                w_dres.status = fgsr_pkg::ST_STAMPED;
                w_dres.gen    = w_sin ? 16'(w_gen) : '0;
            end
            fgsr_pkg::OP_CHECK: begin
                w_dres.status = fgsr_pkg::ST_CHECKED;
                w_dres.cur    = w_cur;
            end
            fgsr_pkg::OP_RELEASE: begin
                if (!w_cur || !w_qok || 32'(r_cmd.dom) >= DOMAIN_COUNT)
                    w_dres.status = fgsr_pkg::ST_INVALID;
                else if (r_rpend)
                    w_dres.status = fgsr_pkg::ST_PENDING;
                else if (!w_free_any)
                    w_dres.status = fgsr_pkg::ST_FULL;
                else begin
                    w_dres.status = fgsr_pkg::ST_ACCEPTED;
                    w_acc         = 1'b1;
                end
            end
            default: w_dres.status = fgsr_pkg::ST_NONE;
        endcase
    end

    always_comb begin
        w_fres        = '0;
        w_fres.status = fgsr_pkg::ST_FREED;
        w_fres.slot   = 10'(w_fslot);
        w_fres.dom    = r_ed[r_best];
        w_lres        = r_hold;
        w_lres.last   = 1'b1;
        w_nres        = '0;
        w_nres.status = fgsr_pkg::ST_NONE;
        w_nres.last   = 1'b1;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            fgsr_pkg::S_CLEAR:  if (32'(r_clr) == SLOT_COUNT - 1) n_st = fgsr_pkg::S_IDLE;
            fgsr_pkg::S_IDLE:   if (i_cmd_valid && !r_ov) n_st = fgsr_pkg::S_READ;
            fgsr_pkg::S_READ:   n_st = fgsr_pkg::S_DECIDE;
            fgsr_pkg::S_DECIDE: begin
                if (r_cmd.op == fgsr_pkg::OP_PROCESS && w_qok) n_st = fgsr_pkg::S_SCAN;
                else n_st = fgsr_pkg::S_EMIT;
            end
            fgsr_pkg::S_SCAN:   if (w_scan_end) n_st = fgsr_pkg::S_PICK;
            fgsr_pkg::S_PICK:   n_st = fgsr_pkg::S_FREE;
            fgsr_pkg::S_FREE:   n_st = fgsr_pkg::S_EMIT;
            fgsr_pkg::S_EMIT: begin
                if (!r_ov) begin
                    if (r_cmd.op == fgsr_pkg::OP_PROCESS && w_qok && r_hav) begin
                        if (r_n != 6'(fgsr_pkg::MAX_RESULTS - 1)) n_st = fgsr_pkg::S_SCAN;
                        else n_st = fgsr_pkg::S_EMIT;
                    end else n_st = fgsr_pkg::S_IDLE;
                end
            end
            default: n_st = fgsr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= fgsr_pkg::S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_ev    <= '0;
            r_arr   <= '0;
            r_hav   <= 1'b0;
            r_hheld <= 1'b0;
            r_n     <= '0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_res_ready) r_ov <= 1'b0;
            case (r_st)
                fgsr_pkg::S_CLEAR: r_clr <= r_clr + SW'(1);
                fgsr_pkg::S_IDLE: begin
                    if (i_cmd_valid && !r_ov) begin
                        r_cmd   <= i_cmd;
                        r_n     <= '0;
                        r_hheld <= 1'b0;
                    end
                end
                fgsr_pkg::S_DECIDE: begin
                    r_idx <= '0;
                    r_hav <= 1'b0;
                    r_res <= w_dres;
                    if (w_acc) begin
                        r_ev[w_free_idx] <= 1'b1;
                        r_ef[w_free_idx] <= r_cmd.fence;
                        r_es[w_free_idx] <= w_slot;
                        r_ed[w_free_idx] <= r_cmd.dom;
                        r_eq[w_free_idx] <= r_cmd.queue;
                        r_ea[w_free_idx] <= r_arr;
                        r_arr <= r_arr + 16'd1;
                    end
                end
                fgsr_pkg::S_SCAN: begin
                    if (w_cand && w_better) begin
                        r_best <= r_idx;
                        r_hav  <= 1'b1;
                    end
                    r_idx <= w_scan_end ? '0 : r_idx + PW'(1);
                end
                fgsr_pkg::S_FREE: begin
                    if (r_hav) begin
                        r_ev[r_best] <= 1'b0;
                        for (int i = 0; i < PENDING_DEPTH; i++) begin
                            if (r_ev[i] && r_ea[i] > r_ea[r_best]) r_ea[i] <= r_ea[i] - 16'd1;
                        end
                        if (r_arr != 16'd0) r_arr <= r_arr - 16'd1;
                    end
                end
                fgsr_pkg::S_EMIT: begin
                    if (!r_ov) begin
                        if (r_cmd.op != fgsr_pkg::OP_PROCESS || !w_qok) begin
                            r_ov <= 1'b1;
                        end else if (r_hav) begin
                            // previous free goes out now, this one waits for the next round
                            if (r_hheld) begin
                                r_ov  <= 1'b1;
                                r_res <= r_hold;
                            end
                            r_hold  <= w_fres;
                            r_hheld <= 1'b1;
                            r_n     <= r_n + 6'd1;
                            r_hav   <= 1'b0;
                        end else begin
                            r_ov    <= 1'b1;
                            r_res   <= r_hheld ? w_lres : w_nres;
                            r_hheld <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (r_st == fgsr_pkg::S_CLEAR) begin
            m_gen[r_clr]  <= '0;
            m_pend[r_clr] <= 1'b0;
        end
        if (r_st == fgsr_pkg::S_READ) begin
            r_rgen  <= m_gen[w_slot];
            r_rpend <= m_pend[w_slot];
        end
        if (r_st == fgsr_pkg::S_PICK) begin
            r_rgen <= m_gen[w_fslot];
        end
        if (r_st == fgsr_pkg::S_DECIDE && w_acc) begin
            m_pend[w_slot] <= 1'b1;
        end
        if (r_st == fgsr_pkg::S_FREE && r_hav) begin
            m_gen[w_fslot]  <= r_rgen + GEN_BITS'(1);
            m_pend[w_fslot] <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 6'(fgsr_pkg::MAX_RESULTS)) else $error("too many frees");
    a_idle_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> r_st == fgsr_pkg::S_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_res_ready |=> r_ov) else $error("result dropped");
`endif
endmodule

// ===== sv/fence_gated_slot_reclaim_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fence_gated_slot_reclaim_top
// Generational slot handles with fence-gated deferred frees.
//
// channel  dir  tdata                                       tlast
// s_axis   in   op,slot,gen,hvalid,dom,queue,fence,done     -
// m_axis   out  status,cur_gen,is_current,slot,domain       last
//
// Stamp/check/release: the item passes the read, decide and emit states; the
// next item is taken the cycle after the result is accepted. Process: one
// scan/pick/free/emit round per freed slot, plus a final round that finds
// nothing unless MAX_RESULTS frees were made; each free item goes out one
// round late so its last flag is known. A full result register stalls the
// rounds. Synchronous active-low reset, then S_CLEAR zeroes the slot tables.
// Input queue of two items decouples the front from the scan engine.
// ---------------------------------------------------------------------------
module fence_gated_slot_reclaim_top #(
    parameter int SLOT_COUNT    = fgsr_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS      = fgsr_pkg::GEN_BITS_DEF,
    parameter int PENDING_DEPTH = fgsr_pkg::PENDING_DEPTH_DEF,
    parameter int QUEUE_COUNT   = fgsr_pkg::QUEUE_COUNT_DEF,
    parameter int DOMAIN_COUNT  = fgsr_pkg::DOMAIN_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // op, slot_index, generation, handle_valid, domain, queue_id, fence, completed
    input  logic [fgsr_pkg::IN_TW-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, current_generation, is_current, freed_slot, freed_domain
    output logic [fgsr_pkg::OUT_TW-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    logic           w_cv, w_cr;
    fgsr_pkg::t_cmd w_cmd;
    fgsr_pkg::t_res w_res;

    fgsr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    fgsr_back #(
        .SLOT_COUNT(SLOT_COUNT), .GEN_BITS(GEN_BITS), .PENDING_DEPTH(PENDING_DEPTH),
        .QUEUE_COUNT(QUEUE_COUNT), .DOMAIN_COUNT(DOMAIN_COUNT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {{(fgsr_pkg::OUT_TW - fgsr_pkg::OUT_W){1'b0}},
                           w_res.dom, w_res.slot, w_res.cur, w_res.gen, w_res.status};
    assign m_axis_tlast = w_res.last;
endmodule

// ===== dv/fgsr_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fgsr_checker
// Watches both streams of the slot reclaim block, predicts the result items
// of every accepted command, and compares them in order, field by field.
// ---------------------------------------------------------------------------
module fgsr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  logic [fgsr_pkg::IN_TW-1:0]    i_cmd_data,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [fgsr_pkg::OUT_TW-1:0]   i_res_data,
    input  logic                          i_res_last,
    output int                            o_fail_count,
    output int                            o_outstanding
);

    localparam int SLOTS = fgsr_pkg::SLOT_COUNT_DEF;
    localparam int DEPTH = fgsr_pkg::PENDING_DEPTH_DEF;

    logic [15:0] slot_gen [SLOTS];
    logic        slot_busy [SLOTS];
    logic        ent_used [DEPTH];
    logic [63:0] ent_fence [DEPTH];
    logic [9:0]  ent_slot [DEPTH];
    logic [3:0]  ent_dom [DEPTH];
    logic [1:0]  ent_queue [DEPTH];
    int          ent_order [DEPTH];
    int          order_next;
    fgsr_pkg::t_res expected_q [$];

    function automatic fgsr_pkg::t_res mk(fgsr_pkg::t_status st, logic [15:0] g, logic c,
                                          logic [9:0] s, logic [3:0] d, logic l);
        fgsr_pkg::t_res r;
        r.status = st; r.gen = g; r.cur = c; r.slot = s; r.dom = d; r.last = l;
        return r;
    endfunction

    task automatic expect_item(fgsr_pkg::t_res r);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch %s: got %0h want %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic reclaim_predict(logic [fgsr_pkg::IN_TW-1:0] d);
        fgsr_pkg::t_op op;
        logic [9:0]  slot;
        logic [15:0] gen;
        logic        hv;
        logic [3:0]  dom;
        logic [1:0]  q;
        logic [63:0] fence, done;
        int          free_idx, best, n;
        logic        cur;
        op = fgsr_pkg::t_op'(d[1:0]); slot = d[11:2]; gen = d[27:12]; hv = d[28];
        dom = d[32:29]; q = d[34:33]; fence = d[98:35]; done = d[162:99];
        cur = hv && slot_gen[slot] == gen;
        case (op)
            fgsr_pkg::OP_STAMP:
                expect_item(mk(fgsr_pkg::ST_STAMPED, slot_gen[slot], 1'b0, 10'd0, 4'd0, 1'b1));
            fgsr_pkg::OP_CHECK:
                expect_item(mk(fgsr_pkg::ST_CHECKED, 16'd0, cur, 10'd0, 4'd0, 1'b1));
            fgsr_pkg::OP_RELEASE: begin
                free_idx = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (!ent_used[i] && free_idx < 0) free_idx = i;
                if (!cur)
                    expect_item(mk(fgsr_pkg::ST_INVALID, 16'd0, 1'b0, 10'd0, 4'd0, 1'b1));
                else if (slot_busy[slot])
                    expect_item(mk(fgsr_pkg::ST_PENDING, 16'd0, 1'b0, 10'd0, 4'd0, 1'b1));
                else if (free_idx < 0)
                    expect_item(mk(fgsr_pkg::ST_FULL, 16'd0, 1'b0, 10'd0, 4'd0, 1'b1));
                else begin
                    ent_used[free_idx] = 1; ent_fence[free_idx] = fence;
                    ent_slot[free_idx] = slot; ent_dom[free_idx] = dom;
                    ent_queue[free_idx] = q; ent_order[free_idx] = order_next;
                    order_next++;
                    slot_busy[slot] = 1;
                    expect_item(mk(fgsr_pkg::ST_ACCEPTED, 16'd0, 1'b0, 10'd0, 4'd0, 1'b1));
                end
            end
            default: begin
                n = 0;
                while (n < fgsr_pkg::MAX_RESULTS) begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!ent_used[i] || ent_queue[i] != q || ent_fence[i] > done)
                            continue;
                        if (best < 0 || ent_fence[i] < ent_fence[best] ||
                            (ent_fence[i] == ent_fence[best] &&
                             ent_order[i] < ent_order[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    ent_used[best] = 0;
                    slot_gen[ent_slot[best]] = slot_gen[ent_slot[best]] + 16'd1;
                    slot_busy[ent_slot[best]] = 0;
                    expect_item(mk(fgsr_pkg::ST_FREED, 16'd0, 1'b0, ent_slot[best],
                                   ent_dom[best], 1'b0));
                    n++;
                end
                if (n == 0)
                    expect_item(mk(fgsr_pkg::ST_NONE, 16'd0, 1'b0, 10'd0, 4'd0, 1'b1));
                else
                    expected_q[$].last = 1;
            end
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        order_next = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_gen[i] = 0; slot_busy[i] = 0;
        end
        for (int i = 0; i < DEPTH; i++) ent_used[i] = 0;
    end

    always @(posedge i_clk) begin
        fgsr_pkg::t_res w;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected item", 64'(i_res_data), 64'd0);
                end else begin
                    w = expected_q.pop_front();
                    if (i_res_data[2:0] != w.status)
                        report("status", 64'(i_res_data[2:0]), 64'(w.status));
                    if (i_res_data[18:3] != w.gen)
                        report("generation", 64'(i_res_data[18:3]), 64'(w.gen));
                    if (i_res_data[19] != w.cur)
                        report("is_current", 64'(i_res_data[19]), 64'(w.cur));
                    if (i_res_data[29:20] != w.slot)
                        report("slot", 64'(i_res_data[29:20]), 64'(w.slot));
                    if (i_res_data[33:30] != w.dom)
                        report("domain", 64'(i_res_data[33:30]), 64'(w.dom));
                    if (i_res_last != w.last)
                        report("last", 64'(i_res_last), 64'(w.last));
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                reclaim_predict(i_cmd_data);
        end
        o_outstanding = expected_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives stamp, release, check and process commands into the slot reclaim
// block with random gaps and back-pressure; the checker judges the results.
// ---------------------------------------------------------------------------
module testbench;

    logic                         i_clk = 0;
    logic                         i_rst_n = 0;
    logic                         s_tvalid = 0;
    logic                         s_tready;
    logic [fgsr_pkg::IN_TW-1:0]   s_tdata = '0;   // op, slot, gen, hvalid, dom, queue, fence, done
    logic                         m_tvalid;
    logic                         m_tready = 0;
    logic [fgsr_pkg::OUT_TW-1:0]  m_tdata;        // status, cur_gen, is_current, slot, domain
    logic                         m_tlast;
    int                           fails;
    int                           outstanding;
    logic                         quiet = 0;
    int                           stall_left = 0;

    always #4 i_clk = ~i_clk;

    fence_gated_slot_reclaim_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
        .m_axis_tlast(m_tlast)
    );

    fgsr_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(s_tvalid), .i_cmd_ready(s_tready), .i_cmd_data(s_tdata),
        .i_res_valid(m_tvalid), .i_res_ready(m_tready), .i_res_data(m_tdata),
        .i_res_last(m_tlast), .o_fail_count(fails), .o_outstanding(outstanding)
    );

    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            m_tready <= i_rst_n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if ($urandom_range(5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    function automatic logic [fgsr_pkg::IN_TW-1:0] pack(fgsr_pkg::t_op op, logic [9:0] slot,
            logic [15:0] gen, logic hv, logic [3:0] dom, logic [1:0] q, logic [63:0] fence,
            logic [63:0] done);
        logic [fgsr_pkg::IN_TW-1:0] d;
        d = '0;
        d[1:0] = op; d[11:2] = slot; d[27:12] = gen; d[28] = hv;
        d[32:29] = dom; d[34:33] = q; d[98:35] = fence; d[162:99] = done;
        return d;
    endfunction

    task automatic send(logic [fgsr_pkg::IN_TW-1:0] d);
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_fence(int top);
        int r;
        r = $urandom_range(9);
        if (r == 0) return '1;
        if (r == 1) return {$urandom, $urandom};
        return 64'($urandom_range(0, top));
    endfunction

    initial begin
        logic [9:0]    sl;
        logic [15:0]   g;
        int            r;
        fgsr_pkg::t_op op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(pack(fgsr_pkg::OP_STAMP, 0, 0, 1, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_STAMP, 1023, 0, 1, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_CHECK, 1023, 16'hFFFF, 1, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_CHECK, 1023, 0, 0, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_CHECK, 1023, 0, 1, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_RELEASE, 5, 0, 0, 15, 3, 0, 0));
        send(pack(fgsr_pkg::OP_RELEASE, 5, 16'h8000, 1, 15, 3, 0, 0));
        send(pack(fgsr_pkg::OP_RELEASE, 5, 0, 1, 15, 3, 0, 0));
        send(pack(fgsr_pkg::OP_RELEASE, 5, 0, 1, 15, 3, 0, 0));
        send(pack(fgsr_pkg::OP_RELEASE, 1023, 0, 1, 0, 0, '1, 0));
        send(pack(fgsr_pkg::OP_RELEASE, 6, 0, 1, 3, 0, 7, 0));
        send(pack(fgsr_pkg::OP_RELEASE, 7, 0, 1, 4, 0, 7, 0));
        send(pack(fgsr_pkg::OP_PROCESS, 0, 0, 1, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_PROCESS, 0, 0, 1, 0, 3, 0, 0));
        send(pack(fgsr_pkg::OP_CHECK, 5, 1, 1, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_STAMP, 5, 0, 1, 0, 0, 0, 0));
        send(pack(fgsr_pkg::OP_PROCESS, 0, 0, 1, 0, 0, 0, 64'd7));
        send(pack(fgsr_pkg::OP_PROCESS, 0, 0, 1, 0, 0, 0, '1));
        send(pack(fgsr_pkg::OP_PROCESS, 0, 0, 1, 0, 1, 0, '1));

        for (int k = 0; k < 420; k++) begin
            if (k == 330) quiet = 1;
            r = $urandom_range(99);
            op = r < 45 ? fgsr_pkg::OP_RELEASE : r < 65 ? fgsr_pkg::OP_PROCESS :
                 r < 80 ? fgsr_pkg::OP_STAMP : fgsr_pkg::OP_CHECK;
            sl = $urandom_range(9) < 8 ? 10'($urandom_range(0, 63)) : 10'($urandom);
            g = $urandom_range(19) < 17 ? u_chk.slot_gen[sl] : 16'($urandom);
            send(pack(op, sl, g, $urandom_range(19) != 0, 4'($urandom), 2'($urandom),
                      pick_fence(200), pick_fence(250)));
        end
        s_tvalid <= 0;
        quiet = 1;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fgsr_pkg.sv
sv/fgsr_front.sv
sv/fgsr_back.sv
sv/fence_gated_slot_reclaim_top.sv
dv/fgsr_checker.sv
dv/testbench.sv
